>>> rtl/qap_pkg.sv
package qap_pkg;
	localparam int MaxSize = 32;
	localparam int IdxW = $clog2(MaxSize);
	localparam int EntryW = 16;
	localparam int AddrW = 2 * IdxW;
	localparam int AccW = 48;
	localparam int ProdW = 2 * EntryW + 2;

	typedef enum logic [2:0] {
		K_WR_FLOW = 3'd0,
		K_WR_COST = 3'd1,
		K_WR_ASSIGN = 3'd2,
		K_FULL = 3'd3,
		K_PARTIAL = 3'd4,
		K_LAST = 3'd5,
		K_SWAP = 3'd6,
		K_NONE = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	// step mode: which term(s) the datapath forms at the current (i, j)
	typedef enum logic [1:0] {
		M_PAIR,   // A[i][j]*B[p[i]][p[j]]
		M_SWAP    // one of the swap delta products
	} mode_t;

	typedef struct packed {
		logic clear;     // zero accumulator
		logic step;      // issue one term at (i, j)
		logic [1:0] sub; // swap sub-product 0..3
		mode_t mode;
		logic [IdxW-1:0] i;
		logic [IdxW-1:0] j;
	} dp_cmd_t;
endpackage

>>> rtl/qap_objective_and_swap_delta_top.sv
// each query walks its terms (L*L full/partial with L = n for full, 2L-1 last added,
// 4n swap delta); a query whose answer is zero by rule walks none
// throughput: one query in flight; next word taken the cycle after the result is taken
// writes are taken back to back while idle and give no result
// reset (arst_n, async low): size_in_use returns to 32, controller idle;
// matrix and assignment contents are undefined until written
module qap_objective_and_swap_delta_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [5:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] kind,
	input logic [4:0] first_index,
	input logic [4:0] second_index,
	input logic signed [15:0] entry_value,
	input logic [5:0] prefix_length,
	output logic out_valid,
	input logic out_ready,
	output logic signed [47:0] cost_value,
	output logic [1:0] query_kind
);
	import qap_pkg::*;

	logic [5:0] size_q, n;
	logic [4:0] r_q, s_q;
	logic [1:0] qk_q;
	logic busy, drained, zero_res, acc_valid;
	logic is_query, start, wr;
	logic signed [47:0] acc;
	dp_cmd_t cmd;
	kind_t k;

	assign k = kind_t'(kind);
	// effective size, capped at the store depth
	assign n = (size_q > 6'(MaxSize)) ? 6'(MaxSize) : size_q;
	assign in_ready = !busy;
	assign is_query = (k == K_FULL) || (k == K_PARTIAL) || (k == K_LAST) || (k == K_SWAP);
	assign start = in_valid && in_ready && is_query;
	assign wr = in_valid && in_ready && !is_query;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= 6'd32;
		else if (cfg_we) size_q <= cfg_wdata;
	end

	// swap positions and result code held for the whole walk
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= first_index;
			s_q <= second_index;
			qk_q <= 2'(kind - 3'd3);
		end
	end

	qap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(k), .n(n),
		.len(prefix_length), .r(first_index), .s(second_index),
		.drained(drained), .out_taken(out_ready), .cmd(cmd), .busy(busy),
		.out_valid(acc_valid), .zero_res(zero_res)
	);

	qap_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .wr_en(wr), .wr_kind(k), .wa(first_index),
		.wb(second_index), .wv(entry_value), .r(r_q), .s(s_q), .cmd(cmd),
		.drained(drained), .acc(acc)
	);

	assign out_valid = acc_valid;
	assign cost_value = zero_res ? '0 : acc;
	assign query_kind = qk_q;
endmodule

>>> rtl/qap_ctrl.sv
module qap_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input qap_pkg::kind_t kind,
	input logic [5:0] n,
	input logic [5:0] len,
	input logic [4:0] r,
	input logic [4:0] s,
	input logic drained,
	input logic out_taken,
	output qap_pkg::dp_cmd_t cmd,
	output logic busy,
	output logic out_valid,
	output logic zero_res
);
	import qap_pkg::*;

	state_t state_q, state_d;
	logic [5:0] i_q, j_q, lim_q;
	logic [1:0] sub_q;
	logic swap_q, last_q, zero_q;
	logic [5:0] lim;
	logic last_step;
	logic last_diag;

	always_comb begin
		unique case (kind)
			K_FULL: lim = n;
			K_PARTIAL, K_LAST: lim = (len > n) ? n : len;
			default: lim = n;
		endcase
	end

	// last-added: on diagonal only one term, then finish
	assign last_diag = last_q && (i_q == lim_q - 6'd1);

	// end-of-walk detection per mode
	always_comb begin
		if (swap_q)
			last_step = (sub_q == 2'd3) && (i_q == lim_q - 6'd1);
		else if (last_q)
			last_step = last_diag;
		else
			last_step = (i_q == lim_q - 6'd1) && (j_q == lim_q - 6'd1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_RUN;
			ST_RUN: if (zero_q || last_step) state_d = ST_DRAIN;
			ST_DRAIN: if (drained) state_d = ST_OUT;
			ST_OUT: if (out_taken) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0; j_q <= '0; sub_q <= '0; lim_q <= '0;
			swap_q <= 1'b0; last_q <= 1'b0; zero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				swap_q <= (kind == K_SWAP);
				last_q <= (kind == K_LAST);
				lim_q <= lim;
				sub_q <= '0;
				i_q <= '0;
				j_q <= '0;
				if (kind == K_SWAP) begin
					zero_q <= ({1'b0, r} >= n) || ({1'b0, s} >= n) || (r == s);
				end else if (kind == K_LAST) begin
					zero_q <= (lim == 6'd0);
					// walk t = lim-1: (k,t) and (t,k) for k < t, then (t,t)
					i_q <= '0;
					j_q <= '0;
				end else begin
					zero_q <= (lim == 6'd0);
				end
			end else if (state_q == ST_RUN) begin
				if (swap_q) begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) i_q <= i_q + 6'd1;
				end else if (last_q) begin
					// j_q: 0 -> (i,t), 1 -> (t,i); i runs 0..t
					if (j_q == 6'd1 || i_q == lim_q - 6'd1) begin
						j_q <= '0;
						i_q <= i_q + 6'd1;
					end else j_q <= 6'd1;
				end else begin
					if (j_q == lim_q - 6'd1) begin
						j_q <= '0;
						i_q <= i_q + 6'd1;
					end else j_q <= j_q + 6'd1;
				end
			end
		end
	end

	always_comb begin
		cmd = '0;
		cmd.clear = (state_q == ST_IDLE) && start;
		cmd.step = (state_q == ST_RUN) && !zero_q;
		cmd.sub = sub_q;
		cmd.mode = swap_q ? M_SWAP : M_PAIR;
		if (swap_q) begin
			cmd.i = i_q[4:0];
			cmd.j = '0;
		end else if (last_q) begin
			cmd.i = (j_q == 6'd1) ? (lim_q[4:0] - 5'd1) : i_q[4:0];
			cmd.j = (j_q == 6'd1) ? i_q[4:0] : (lim_q[4:0] - 5'd1);
		end else begin
			cmd.i = i_q[4:0];
			cmd.j = j_q[4:0];
		end
		busy = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		zero_res = zero_q;
	end
endmodule

>>> rtl/qap_dpath.sv
module qap_dpath (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input qap_pkg::kind_t wr_kind,
	input logic [4:0] wa,
	input logic [4:0] wb,
	input logic signed [15:0] wv,
	input logic [4:0] r,
	input logic [4:0] s,
	input qap_pkg::dp_cmd_t cmd,
	output logic drained,
	output logic signed [47:0] acc
);
	import qap_pkg::*;

	logic signed [EntryW-1:0] flow_mem [MaxSize*MaxSize];
	logic signed [EntryW-1:0] cost_mem [MaxSize*MaxSize];
	logic [IdxW-1:0] asg [MaxSize];

	always_ff @(posedge clk) begin
		if (wr_en && wr_kind == K_WR_FLOW) flow_mem[{wa, wb}] <= wv;
		if (wr_en && wr_kind == K_WR_COST) cost_mem[{wa, wb}] <= wv;
		if (wr_en && wr_kind == K_WR_ASSIGN) asg[wa] <= wb;
	end

	// stage 1: decide flow index and two cost indexes
	logic [IdxW-1:0] fi, fj, c1r, c1c, c2r, c2c, pr, ps, pk, pi, pj;
	logic skip;
	assign pr = asg[r];
	assign ps = asg[s];
	assign pk = asg[cmd.i];
	assign pi = asg[cmd.i];
	assign pj = asg[cmd.j];

	always_comb begin
		fi = cmd.i; fj = cmd.j;
		c1r = pi; c1c = pj; c2r = pi; c2c = pj;
		skip = 1'b0;
		if (cmd.mode == M_SWAP) begin
			if (cmd.i == r || cmd.i == s) begin
				// diagonal/cross terms, handled once at k == r
				skip = (cmd.i == s);
				case (cmd.sub)
					2'd0: begin fi = r; fj = r; c1r = ps; c1c = ps; c2r = pr; c2c = pr; end
					2'd1: begin fi = r; fj = s; c1r = ps; c1c = pr; c2r = pr; c2c = ps; end
					2'd2: begin fi = s; fj = r; c1r = pr; c1c = ps; c2r = ps; c2c = pr; end
					default: begin fi = s; fj = s; c1r = pr; c1c = pr; c2r = ps; c2c = ps; end
				endcase
			end else begin
				case (cmd.sub)
					2'd0: begin fi = cmd.i; fj = r; c1r = pk; c1c = ps; c2r = pk; c2c = pr; end
					2'd1: begin fi = cmd.i; fj = s; c1r = pk; c1c = pr; c2r = pk; c2c = ps; end
					2'd2: begin fi = r; fj = cmd.i; c1r = ps; c1c = pk; c2r = pr; c2c = pk; end
					default: begin fi = s; fj = cmd.i; c1r = pr; c1c = pk; c2r = ps; c2c = pk; end
				endcase
			end
		end
	end

	// stage 1 registered memory reads
	logic signed [EntryW-1:0] f_s1, c1_s1, c2_s1;
	logic v_s1, sw_s1, v_s2;
	always_ff @(posedge clk) begin
		f_s1 <= flow_mem[{fi, fj}];
		c1_s1 <= cost_mem[{c1r, c1c}];
		c2_s1 <= cost_mem[{c2r, c2c}];
		sw_s1 <= (cmd.mode == M_SWAP);
	end

	// stage 2 product
	logic signed [EntryW:0] diff;
	logic signed [ProdW-1:0] prod_s2;
	assign diff = sw_s1 ? ({c1_s1[EntryW-1], c1_s1} - {c2_s1[EntryW-1], c2_s1})
		: {c1_s1[EntryW-1], c1_s1};
	always_ff @(posedge clk) prod_s2 <= ProdW'(f_s1 * diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; acc <= '0;
		end else begin
			v_s1 <= cmd.step && !skip;
			v_s2 <= v_s1;
			if (cmd.clear) acc <= '0;
			else if (v_s2) acc <= acc + AccW'(prod_s2);
		end
	end

	assign drained = !v_s1 && !v_s2 && !cmd.step;
endmodule

>>> test/tb.sv
module tb;
	import qap_pkg::*;

	// side of the square block of matrix entries that gets loaded
	localparam int Blk = 10;

	// one word on the input side
	typedef struct {
		kind_t k;
		logic [4:0] a;
		logic [4:0] b;
		logic signed [15:0] v;
		logic [5:0] len;
	} query_word_t;

	// one expected answer
	typedef struct {
		logic [47:0] cost;
		logic [1:0] qk;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] kind = '0;
	logic [4:0] first_index = '0;
	logic [4:0] second_index = '0;
	logic signed [15:0] entry_value = '0;
	logic [5:0] prefix_length = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [47:0] cost_value;
	logic [1:0] query_kind;

	qap_objective_and_swap_delta_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.first_index(first_index),
		.second_index(second_index),
		.entry_value(entry_value),
		.prefix_length(prefix_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cost_value(cost_value),
		.query_kind(query_kind)
	);

	// clock, period 4
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// words waiting to be offered, answers waiting to come back
	query_word_t send_q[$];
	answer_t answer_q[$];

	// shadow copy of the block's state
	logic signed [15:0] flow_m [32][32];
	logic signed [15:0] cost_m [32][32];
	logic [4:0] place_m [32];
	int unsigned size_m = 32;

	int pushed = 0;
	int accepted = 0;
	int answers_seen = 0;
	int mismatches = 0;
	int queries_sent = 0;
	longint cycles = 0;
	bit idle_on = 1'b1;
	bit long_stall_req = 1'b0;
	bit took = 1'b0;
	int send_gap = 0;
	int recv_hold = 0;

	// single flow-times-cost term at positions i, j
	function automatic longint pair_term(int i, int j);
		return longint'(flow_m[i][j]) * longint'(cost_m[place_m[i]][place_m[j]]);
	endfunction

	function automatic longint prefix_sum(int len);
		longint acc = 0;
		for (int i = 0; i < len; i++)
			for (int j = 0; j < len; j++)
				acc += pair_term(i, j);
		return acc;
	endfunction

	// what position len-1 adds, diagonal counted once
	function automatic longint last_position_sum(int len);
		longint acc = 0;
		int t;
		if (len == 0)
			return 0;
		t = len - 1;
		for (int i = 0; i < t; i++)
			acc += pair_term(i, t) + pair_term(t, i);
		return acc + pair_term(t, t);
	endfunction

	function automatic longint swap_change(int r, int s, int n);
		longint acc = 0;
		int pr;
		int ps;
		int pk;
		if (r >= n || s >= n || r == s)
			return 0;
		pr = place_m[r];
		ps = place_m[s];
		acc += longint'(flow_m[r][r]) * (longint'(cost_m[ps][ps]) - cost_m[pr][pr]);
		acc += longint'(flow_m[r][s]) * (longint'(cost_m[ps][pr]) - cost_m[pr][ps]);
		acc += longint'(flow_m[s][r]) * (longint'(cost_m[pr][ps]) - cost_m[ps][pr]);
		acc += longint'(flow_m[s][s]) * (longint'(cost_m[pr][pr]) - cost_m[ps][ps]);
		for (int k = 0; k < n; k++) begin
			if (k == r || k == s)
				continue;
			pk = place_m[k];
			acc += longint'(flow_m[k][r]) * (longint'(cost_m[pk][ps]) - cost_m[pk][pr]);
			acc += longint'(flow_m[k][s]) * (longint'(cost_m[pk][pr]) - cost_m[pk][ps]);
			acc += longint'(flow_m[r][k]) * (longint'(cost_m[ps][pk]) - cost_m[pr][pk]);
			acc += longint'(flow_m[s][k]) * (longint'(cost_m[pr][pk]) - cost_m[ps][pk]);
		end
		return acc;
	endfunction

	// update the shadow state for one accepted word and queue its answer
	task automatic predict_cost(query_word_t w);
		int n;
		int len;
		longint val;
		answer_t ans;
		n = (size_m > 32) ? 32 : size_m;
		len = (w.len > n) ? n : w.len;
		case (w.k)
			K_WR_FLOW: begin
				flow_m[w.a][w.b] = w.v;
				return;
			end
			K_WR_COST: begin
				cost_m[w.a][w.b] = w.v;
				return;
			end
			K_WR_ASSIGN: begin
				place_m[w.a] = w.b;
				return;
			end
			K_FULL: val = prefix_sum(n);
			K_PARTIAL: val = prefix_sum(len);
			K_LAST: val = last_position_sum(len);
			K_SWAP: val = swap_change(w.a, w.b, n);
			default: return;
		endcase
		ans.cost = val[47:0];
		ans.qk = 2'(w.k - K_FULL);
		answer_q.push_back(ans);
	endtask

	// sender: a new word goes out once the last one was taken
	always @(negedge clk) begin
		query_word_t w;
		if (!in_valid || took) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (send_q.size() > 0) begin
				w = send_q.pop_front();
				kind <= w.k;
				first_index <= w.a;
				second_index <= w.b;
				entry_value <= w.v;
				prefix_length <= w.len;
				in_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random short stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (long_stall_req) begin
			long_stall_req = 1'b0;
			recv_hold = 3000;
		end
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			recv_hold = $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: input acceptance feeds the predictor, output words are checked
	always @(posedge clk) begin
		query_word_t w;
		answer_t ans;
		cycles++;
		took <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			w.k = kind_t'(kind);
			w.a = first_index;
			w.b = second_index;
			w.v = entry_value;
			w.len = prefix_length;
			predict_cost(w);
			accepted++;
		end
		if (arst_n && out_valid && out_ready) begin
			answers_seen++;
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: cost %0d kind %0d",
						cost_value, query_kind);
			end else begin
				ans = answer_q.pop_front();
				if (cost_value !== ans.cost || query_kind !== ans.qk) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected cost %0d kind %0d, got cost %0d kind %0d",
							$signed(ans.cost), ans.qk, cost_value, query_kind);
				end
			end
		end
		if (cycles > 3000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_word(kind_t k, int a, int b, int v, int len);
		query_word_t w;
		w.k = k;
		w.a = 5'(a);
		w.b = 5'(b);
		w.v = 16'(v);
		w.len = 6'(len);
		send_q.push_back(w);
		pushed++;
		if (k >= K_FULL && k <= K_SWAP)
			queries_sent++;
	endtask

	// sender pauses until every answer is back, then lets the block settle
	task automatic wait_drained();
		while (accepted != pushed || answer_q.size() != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	task automatic set_size(int n);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 6'(n);
		@(negedge clk);
		cfg_we <= 1'b0;
		size_m = n;
	endtask

	// random well-formed traffic: entry rewrites mixed with every query kind;
	// entries and locations stay inside the loaded block
	task automatic random_words(int count, int max_len);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 3)
				queue_word(K_WR_FLOW, $urandom_range(0, Blk - 1), $urandom_range(0, Blk - 1),
					$urandom_range(0, 65535), $urandom_range(0, 63));
			else if (pick < 6)
				queue_word(K_WR_COST, $urandom_range(0, Blk - 1), $urandom_range(0, Blk - 1),
					$urandom_range(0, 65535), $urandom_range(0, 63));
			else if (pick < 8)
				queue_word(K_WR_ASSIGN, $urandom_range(0, 31), $urandom_range(0, Blk - 1),
					$urandom_range(0, 65535), $urandom_range(0, 63));
			else if (pick < 9)
				queue_word(K_FULL, $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 65535), $urandom_range(0, 63));
			else if (pick < 12)
				queue_word(K_PARTIAL, $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 65535),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
						: $urandom_range(0, max_len));
			else if (pick < 15)
				queue_word(K_LAST, $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 65535), $urandom_range(0, 63));
			else if (pick < 19)
				queue_word(K_SWAP, $urandom_range(0, Blk), $urandom_range(0, Blk),
					$urandom_range(0, 65535), $urandom_range(0, 63));
			else
				queue_word(K_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 65535), $urandom_range(0, 63));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// load the leading block of both matrices and place every position inside it,
		// so no query ever reads an unwritten entry
		for (int i = 0; i < Blk; i++)
			for (int j = 0; j < Blk; j++) begin
				queue_word(K_WR_FLOW, i, j, $urandom_range(0, 65535), $urandom_range(0, 63));
				queue_word(K_WR_COST, i, j, $urandom_range(0, 65535), $urandom_range(0, 63));
			end
		for (int i = 0; i < 32; i++)
			queue_word(K_WR_ASSIGN, i, $urandom_range(0, Blk - 1), 0, 0);

		// directed: extreme entries, prefix queries at full size
		queue_word(K_WR_FLOW, 0, 0, 16'sh7fff, 0);
		queue_word(K_WR_COST, Blk - 1, Blk - 1, 16'sh8000, 63);
		queue_word(K_WR_FLOW, Blk - 1, Blk - 1, 16'sh8000, 0);
		queue_word(K_WR_ASSIGN, Blk - 1, Blk - 1, 0, 0);
		queue_word(K_WR_ASSIGN, 0, 0, 0, 0);
		queue_word(K_PARTIAL, 0, 0, 0, 0);
		queue_word(K_PARTIAL, 31, 31, -1, Blk);
		queue_word(K_PARTIAL, 0, 0, 0, 5);
		queue_word(K_LAST, 0, 0, 0, 0);
		queue_word(K_LAST, 0, 0, 0, 1);
		queue_word(K_LAST, 0, 0, 0, Blk);
		queue_word(K_NONE, 3, 4, 0, 10);

		// register value above the store depth is capped
		set_size(45);
		queue_word(K_PARTIAL, 0, 0, 0, 4);
		queue_word(K_LAST, 0, 0, 0, 7);

		// every query kind over the whole loaded block
		set_size(Blk);
		queue_word(K_FULL, 0, 0, 0, 0);
		queue_word(K_PARTIAL, 0, 0, 0, 63);
		queue_word(K_LAST, 0, 0, 0, 63);
		queue_word(K_LAST, 0, 0, 0, 32);
		queue_word(K_SWAP, 0, Blk - 1, 0, 0);
		queue_word(K_SWAP, 7, 7, 0, 0);
		queue_word(K_SWAP, Blk - 1, 0, 0, 0);
		queue_word(K_SWAP, 3, 20, 0, 0);
		queue_word(K_PARTIAL, 0, 0, 0, 2);

		// small instances exercise the out-of-instance swap and long prefix cases
		set_size(1);
		queue_word(K_SWAP, 0, 1, 0, 0);
		queue_word(K_FULL, 0, 0, 0, 0);
		queue_word(K_LAST, 0, 0, 0, 40);
		random_words(25, 1);

		set_size(5);
		random_words(35, 5);

		// receiver holds off while words keep coming: the block backs up
		set_size(3);
		long_stall_req = 1'b1;
		random_words(30, 3);

		set_size(Blk);
		random_words(35, Blk);

		// last part with no idling on either side
		set_size(7);
		idle_on = 1'b0;
		random_words(35, 7);

		while (accepted != pushed || answer_q.size() != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
		$display("covered %0d words, %0d queries, %0d answers over sizes 1 to 32",
			pushed, queries_sent, answers_seen);
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

>>> files.f
rtl/qap_pkg.sv
rtl/qap_ctrl.sv
rtl/qap_dpath.sv
rtl/qap_objective_and_swap_delta_top.sv
test/tb.sv
